[rtl/core/pmtu_pkg.sv]
// Shared types and constants for the prescaled multi-timer unit.
`timescale 1ns / 1ps
package pmtu_pkg;

	localparam int NUM_TIMERS_DEF    = 4;
	localparam int COUNTER_WIDTH_DEF = 32;
	localparam int SCALER_WIDTH_DEF  = 16;
	localparam int MAX_TIMERS        = 7;
	localparam int DATA_W            = 32;
	localparam int WDOG_W            = 3;
	localparam int CTL_W             = 6;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_COUNT  = 2'd0,
		REG_RELOAD = 2'd1,
		REG_CTRL   = 2'd2,
		REG_LATCH  = 2'd3
	} reg_kind_t;

	localparam int CTL_EN    = 0;
	localparam int CTL_PER   = 1;
	localparam int CTL_LOAD  = 2;
	localparam int CTL_IE    = 3;
	localparam int CTL_PEND  = 4;
	localparam int CTL_CHAIN = 5;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [4:0]        reg_address;
		logic [DATA_W-1:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]     read_data;
		logic [MAX_TIMERS-1:0] irq_lines;
		logic                  watchdog_out;
	} out_item_t;

	typedef struct packed {
		logic tick;
		logic scl_tick;
		logic wr_count;
		logic wr_reload;
		logic wr_ctrl;
		logic wdog_sel;
	} cell_cmd_t;

	typedef struct packed {
		logic under;
		logic trip;
		logic pend_next;
	} cell_stat_t;

endpackage

[rtl/core/pmtu_scaler.sv]
// Shared prescaler: counts down each tick, reloads and fires at zero.
`timescale 1ns / 1ps
module pmtu_scaler
	import pmtu_pkg::*;
#(
	parameter int SCALER_WIDTH = SCALER_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tick,
	input  logic                    wr_count,
	input  logic                    wr_reload,
	input  logic [DATA_W-1:0]       wdata,
	output logic                    scl_tick,
	output logic [SCALER_WIDTH-1:0] rd_count,
	output logic [SCALER_WIDTH-1:0] rd_reload
);

	logic [SCALER_WIDTH-1:0] count_q;
	logic [SCALER_WIDTH-1:0] reload_q;

	assign scl_tick  = tick && (count_q == '0);
	assign rd_count  = count_q;
	assign rd_reload = reload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '1;
			reload_q <= '1;
		end else begin
			if (scl_tick) begin
				count_q <= reload_q;
			end else if (tick) begin
				count_q <= count_q - SCALER_WIDTH'(1);
			end else if (wr_count) begin
				count_q <= wdata[SCALER_WIDTH-1:0];
			end
			if (wr_reload) begin
				reload_q <= wdata[SCALER_WIDTH-1:0];
			end
		end
	end

endmodule

[rtl/core/pmtu_cell.sv]
// One timer cell: counter, reload and control; passes underflow to the next cell.
`timescale 1ns / 1ps
module pmtu_cell
	import pmtu_pkg::*;
#(
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_cmd_t                cmd,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     prev_under,
	output cell_stat_t               stat,
	output logic [COUNTER_WIDTH-1:0] rd_count,
	output logic [COUNTER_WIDTH-1:0] rd_reload,
	output logic [CTL_W-1:0]         rd_ctrl
);

	logic [COUNTER_WIDTH-1:0] count_q;
	logic [COUNTER_WIDTH-1:0] reload_q;
	logic en_q, per_q, ie_q, pend_q, chain_q;
	logic src, dec;

	assign src = chain_q ? prev_under : cmd.scl_tick;
	assign dec = cmd.tick && en_q && src;

	assign stat.under     = dec && (count_q == '0);
	assign stat.trip      = stat.under && cmd.wdog_sel;
	assign stat.pend_next = cmd.wr_ctrl ? (pend_q && !wdata[CTL_PEND])
	                                    : (pend_q || (stat.under && ie_q));

	assign rd_count  = count_q;
	assign rd_reload = reload_q;
	assign rd_ctrl   = {chain_q, pend_q, ie_q, 1'b0, per_q, en_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			reload_q <= '0;
			en_q     <= 1'b0;
			per_q    <= 1'b0;
			ie_q     <= 1'b0;
			pend_q   <= 1'b0;
			chain_q  <= 1'b0;
		end else begin
			pend_q <= stat.pend_next;
			if (stat.under) begin
				count_q <= per_q ? reload_q : '1;
				en_q    <= en_q && per_q;
			end else if (dec) begin
				count_q <= count_q - COUNTER_WIDTH'(1);
			end else if (cmd.wr_count) begin
				count_q <= wdata[COUNTER_WIDTH-1:0];
			end else if (cmd.wr_ctrl && wdata[CTL_LOAD]) begin
				count_q <= reload_q;
			end
			if (cmd.wr_reload) begin
				reload_q <= wdata[COUNTER_WIDTH-1:0];
			end
			if (cmd.wr_ctrl) begin
				en_q    <= wdata[CTL_EN];
				per_q   <= wdata[CTL_PER];
				ie_q    <= wdata[CTL_IE];
				chain_q <= wdata[CTL_CHAIN];
			end
		end
	end

endmodule

[rtl/core/prescaled_multi_timer_unit.sv]
// Timer unit top level: prescaler, chain of timer cells, register access, result register.
// One transaction per clock: a tick, register read or register write is applied to the
// scaler and all timer cells in the cycle it is accepted, and its single result is loaded
// into the output register the same edge, so a new transaction is taken every cycle while
// the result side keeps up. The per-cycle path is the scaler zero check followed by the
// underflow ripple through the NUM_TIMERS cells for chained timers. Timer n sits at word
// addresses 4n..4n+3; the watchdog timer index is set through the configuration channel.
`timescale 1ns / 1ps
module prescaled_multi_timer_unit
	import pmtu_pkg::*;
#(
	parameter int NUM_TIMERS    = NUM_TIMERS_DEF,
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
	parameter int SCALER_WIDTH  = SCALER_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WDOG_W-1:0] cfg_data
);

	logic              accept;
	logic              op_tick, op_read, op_write;
	logic [2:0]        sel_n;
	reg_kind_t         sel_k;
	logic [WDOG_W-1:0] wdog_q;
	logic              trip_q;
	logic              trip_next;
	logic              out_valid_q;
	out_item_t         out_q;

	logic                    scl_tick;
	logic [SCALER_WIDTH-1:0] scl_rd_count, scl_rd_reload;

	cell_cmd_t  [NUM_TIMERS-1:0]                    cmd;
	cell_stat_t [NUM_TIMERS-1:0]                    stat;
	logic       [NUM_TIMERS:0]                      under_chain;
	logic       [NUM_TIMERS-1:0][COUNTER_WIDTH-1:0] rd_count, rd_reload;
	logic       [NUM_TIMERS-1:0][CTL_W-1:0]         rd_ctrl;

	logic [DATA_W-1:0]     rdata;
	logic [MAX_TIMERS-1:0] irq_next;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign op_tick  = accept && (opcode_t'(in_data.opcode) == OP_TICK);
	assign op_read  = accept && (opcode_t'(in_data.opcode) == OP_READ);
	assign op_write = accept && (opcode_t'(in_data.opcode) == OP_WRITE);
	assign sel_n    = in_data.reg_address[4:2];
	assign sel_k    = reg_kind_t'(in_data.reg_address[1:0]);

	pmtu_scaler #(
		.SCALER_WIDTH(SCALER_WIDTH)
	) u_scaler (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (op_tick),
		.wr_count (op_write && (sel_n == 3'd0) && (sel_k == REG_COUNT)),
		.wr_reload(op_write && (sel_n == 3'd0) && (sel_k == REG_RELOAD)),
		.wdata    (in_data.write_data),
		.scl_tick (scl_tick),
		.rd_count (scl_rd_count),
		.rd_reload(scl_rd_reload)
	);

	assign under_chain[0] = 1'b0;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		logic hit;
		assign hit              = op_write && (sel_n == 3'(i + 1));
		assign cmd[i].tick      = op_tick;
		assign cmd[i].scl_tick  = scl_tick;
		assign cmd[i].wr_count  = hit && (sel_k == REG_COUNT);
		assign cmd[i].wr_reload = hit && (sel_k == REG_RELOAD);
		assign cmd[i].wr_ctrl   = hit && (sel_k == REG_CTRL);
		assign cmd[i].wdog_sel  = (wdog_q == WDOG_W'(i + 1));

		pmtu_cell #(
			.COUNTER_WIDTH(COUNTER_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd[i]),
			.wdata     (in_data.write_data),
			.prev_under(under_chain[i]),
			.stat      (stat[i]),
			.rd_count  (rd_count[i]),
			.rd_reload (rd_reload[i]),
			.rd_ctrl   (rd_ctrl[i])
		);

		assign under_chain[i+1] = stat[i].under;
	end

	always_comb begin
		rdata     = '0;
		irq_next  = '0;
		trip_next = trip_q;
		if (op_read) begin
			if (sel_n == 3'd0) begin
				unique case (sel_k)
					REG_COUNT:  rdata = DATA_W'(scl_rd_count);
					REG_RELOAD: rdata = DATA_W'(scl_rd_reload);
					REG_CTRL:   rdata = DATA_W'(wdog_q);
					REG_LATCH:  rdata = '0;
				endcase
			end
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (sel_n == 3'(i + 1)) begin
					unique case (sel_k)
						REG_COUNT:  rdata = DATA_W'(rd_count[i]);
						REG_RELOAD: rdata = DATA_W'(rd_reload[i]);
						REG_CTRL:   rdata = DATA_W'(rd_ctrl[i]);
						REG_LATCH:  rdata = '0;
					endcase
				end
			end
		end
		for (int i = 0; i < NUM_TIMERS; i++) begin
			irq_next[i] = stat[i].pend_next;
			if (stat[i].trip) begin
				trip_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wdog_q      <= '0;
			trip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				wdog_q <= cfg_data;
			end
			if (accept) begin
				trip_q      <= trip_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.read_data    <= rdata;
			out_q.irq_lines    <= irq_next;
			out_q.watchdog_out <= trip_next;
		end
	end

endmodule

[rtl/core/pmtu_checker.sv]
// Port-level checks for the timer unit, bound to the top level.
`timescale 1ns / 1ps
module pmtu_checker
	import pmtu_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input in_item_t          in_data,
	input logic              out_valid,
	input logic              out_ready,
	input out_item_t         out_data
);

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a waiting result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted transaction produced no result");

	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (opcode_t'(in_data.opcode) != OP_READ))
		|=> (out_data.read_data == '0))
		else $error("nonzero read data on a non-read transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

bind prescaled_multi_timer_unit pmtu_checker u_pmtu_checker (.*);
